FILE: design/nu_mut_pkg.sv
// Shared constants, types and latencies of the non-uniform mutation pipeline.
`default_nettype none
package nu_mut_pkg;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W    = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHAPE    = 1'b1;

  localparam logic [31:0] MAX_ITER_RST = 32'd1;
  localparam logic [23:0] SHAPE_RST    = 24'd327680;   // 5.0 in Q8.16

  // log2 result: 5 integer bits, 32 fraction bits
  localparam int unsigned LOG_W  = 37;
  // exponent argument of 2^-t: 13 integer bits, 32 fraction bits
  localparam int unsigned T_W    = 45;
  // Q.32 value in [0,1]
  localparam int unsigned Q_W    = 33;
  localparam logic [Q_W-1:0] ONE_Q32 = 33'h1_0000_0000;

  localparam logic [31:0] LN2_Q32 = 32'hB17217F8;
  localparam int unsigned NTERM   = 15;   // series terms 2..16

  localparam int unsigned LOG_LAT = 33;
  localparam int unsigned EXP_LAT = 2 + 3 * NTERM;
  // input reg, log2, 3 scale stages, exp2, 2 product stages, exp2, 4 output stages
  localparam int unsigned PIPE_DEPTH = 1 + LOG_LAT + 3 + EXP_LAT + 2 + EXP_LAT + 4;

  typedef struct packed {
    logic signed [31:0] x;
    logic               up;
    logic               rz;      // random fraction is zero
    logic               nostep;  // exponent is zero: no move
  } side_t;

endpackage
`default_nettype wire

FILE: design/non_uniform_mutation.sv
// Non-uniform mutation of one solution component. One transaction per cycle in
// steady state while the output is not stalled. The pipeline depth is set by three
// 33-stage log2 pipelines (one squaring multiply per fraction bit) and two 47-stage
// exp2 pipelines (three stages per series term). A stall on the output halts the
// whole pipeline in place. The user must write configuration only between bursts,
// when no transaction is in flight; the block itself does not enforce this.
`default_nettype none
module non_uniform_mutation
  import nu_mut_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [31:0]   in_component_value,
  input  logic                 in_move_up,
  input  logic [31:0]          in_uniform_fraction,
  input  logic [31:0]          in_iteration,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [31:0]   out_mutated_value,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_wdata
);
  logic [31:0] max_iter_r;
  logic [23:0] shape_r;
  logic [PIPE_DEPTH-1:0] vld_r;
  logic ce;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_iter_r <= MAX_ITER_RST;
      shape_r    <= SHAPE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAX_ITER: max_iter_r <= cfg_wdata;
        CFG_SHAPE:    shape_r    <= cfg_wdata[23:0];
        default: ;
      endcase
    end
  end

  assign ce        = !vld_r[PIPE_DEPTH-1] || out_ready;
  assign in_ready  = ce;
  assign out_valid = vld_r[PIPE_DEPTH-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ce) begin
      vld_r <= {vld_r[PIPE_DEPTH-2:0], in_valid};
    end
  end

  // input register
  logic signed [31:0] x0_r;
  logic        up0_r;
  logic [31:0] r0_r, it0_r;
  always_ff @(posedge clk) begin
    if (ce) begin
      x0_r  <= in_component_value;
      up0_r <= in_move_up;
      r0_r  <= in_uniform_fraction;
      it0_r <= in_iteration;
    end
  end

  logic [31:0] rem0;
  side_t side0, side1, side2_r, side3_r, side4;
  assign rem0  = max_iter_r - it0_r;
  assign side0 = '{x: x0_r, up: up0_r, rz: (r0_r == 32'd0), nostep: (it0_r >= max_iter_r)};

  logic [LOG_W-1:0] lmax, lrem, lr, lr1;
  nu_mut_log2 u_lmax (.clk(clk), .ce(ce), .v(max_iter_r), .lg(lmax));
  nu_mut_log2 u_lrem (.clk(clk), .ce(ce), .v(rem0),       .lg(lrem));
  nu_mut_log2 u_lr   (.clk(clk), .ce(ce), .v(r0_r),       .lg(lr));

  nu_mut_delay #(.W($bits(side_t)), .D(LOG_LAT + 3 + EXP_LAT)) u_dly_side1 (
    .clk(clk), .ce(ce), .d(side0), .q(side1)
  );
  nu_mut_delay #(.W(LOG_W), .D(3 + EXP_LAT)) u_dly_lr (
    .clk(clk), .ce(ce), .d(lr), .q(lr1)
  );

  // progress exponent t = B * (log2 max - log2 (max - it))
  logic [LOG_W-1:0] lmag_r;
  logic [55:0]      bl_r;
  logic [28:0]      bh_r;
  logic [T_W-1:0]   t1_r;
  logic [60:0]      bsum;
  assign bsum = {bh_r, 32'd0} + 61'(bl_r);

  always_ff @(posedge clk) begin
    if (ce) begin
      lmag_r <= (lmax >= lrem) ? lmax - lrem : '0;
      bl_r   <= 56'(shape_r) * 56'(lmag_r[31:0]);
      bh_r   <= 29'(shape_r) * 29'(lmag_r[LOG_W-1:32]);
      t1_r   <= T_W'(bsum >> 16);
    end
  end

  logic [Q_W-1:0] e1;
  nu_mut_exp2 u_exp_e (.clk(clk), .ce(ce), .t(t1_r), .e(e1));

  // r^e = 2^-((32 - log2 r') * e)
  logic [Q_W-1:0] esel;
  logic [37:0]    aval;
  logic [38:0]    ph_r;
  logic [64:0]    pl_r;
  logic [T_W-1:0] t2_r;
  assign esel = side1.nostep ? '0 : e1;
  assign aval = (38'd32 << 32) - 38'(lr1);

  always_ff @(posedge clk) begin
    if (ce) begin
      ph_r    <= 39'(aval[37:32]) * 39'(esel);
      pl_r    <= 65'(aval[31:0]) * 65'(esel);
      side2_r <= '{x: side1.x, up: side1.up, rz: side1.rz, nostep: (esel == '0)};
      t2_r    <= T_W'(ph_r + 39'(pl_r[64:32]));
      side3_r <= side2_r;
    end
  end

  logic [Q_W-1:0] p2;
  nu_mut_exp2 u_exp_p (.clk(clk), .ce(ce), .t(t2_r), .e(p2));
  nu_mut_delay #(.W($bits(side_t)), .D(EXP_LAT)) u_dly_side4 (
    .clk(clk), .ce(ce), .d(side3_r), .q(side4)
  );

  // step and fold
  logic [Q_W-1:0]     pval;
  logic signed [33:0] span;
  logic [Q_W-1:0]     k_r;
  logic [31:0]        mag_r, d_r;
  logic signed [31:0] xf1_r, xf2_r;
  logic               add1_r, add2_r;
  logic [64:0]        dprod;
  logic signed [33:0] v_r;
  logic [33:0]        whi, wlo;
  logic signed [33:0] vfold;
  logic signed [31:0] out_r;

  assign pval  = side4.nostep ? ONE_Q32 : (side4.rz ? '0 : p2);
  assign span  = side4.up ? (34'sh0_4000_0000 - 34'(side4.x))
                          : (34'sh0_4000_0000 + 34'(side4.x));
  assign dprod = 65'(mag_r) * 65'(k_r);

  always_ff @(posedge clk) begin
    if (ce) begin
      k_r    <= ONE_Q32 - pval;
      mag_r  <= span[33] ? 32'(-span) : 32'(span);
      add1_r <= side4.up ^ span[33];
      xf1_r  <= side4.x;

      d_r    <= dprod[63:32];
      add2_r <= add1_r;
      xf2_r  <= xf1_r;

      v_r    <= add2_r ? 34'(xf2_r) + 34'(d_r) : 34'(xf2_r) - 34'(d_r);
      out_r  <= vfold[31:0];
    end
  end

  // fold by whole multiples of 2 into [-1,1]
  assign whi = v_r - 34'sd1073741825;
  assign wlo = -34'sd1073741825 - v_r;
  always_comb begin
    if (v_r > 34'sh0_4000_0000)
      vfold = v_r - ((34'(whi[33:31]) + 34'd1) << 31);
    else if (v_r < -34'sh0_4000_0000)
      vfold = v_r + ((34'(wlo[33:31]) + 34'd1) << 31);
    else
      vfold = v_r;
  end

  assign out_mutated_value = out_r;
endmodule
`default_nettype wire

FILE: design/nu_mut_delay.sv
// Plain stallable delay line for side data.
`default_nettype none
module nu_mut_delay #(
  parameter int unsigned W = 1,
  parameter int unsigned D = 1
) (
  input  logic         clk,
  input  logic         ce,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);
  logic [W-1:0] sr_r [0:D-1];

  always_ff @(posedge clk) begin
    if (ce) begin
      sr_r[0] <= d;
      for (int i = 1; i < D; i++) sr_r[i] <= sr_r[i-1];
    end
  end

  assign q = sr_r[D-1];
endmodule
`default_nettype wire

FILE: design/nu_mut_log2.sv
// Pipelined log2 of a 32-bit integer: normalise, then one squaring per fraction bit.
`default_nettype none
module nu_mut_log2
  import nu_mut_pkg::*;
(
  input  logic             clk,
  input  logic             ce,
  input  logic [31:0]      v,
  output logic [LOG_W-1:0] lg
);
  logic [31:0] m_r [0:32];
  logic [4:0]  n_r [0:32];
  logic [31:0] f_r [0:32];
  logic [4:0]  msb;

  always_comb begin
    msb = '0;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) msb = 5'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      m_r[0] <= v << (5'd31 - msb);
      n_r[0] <= msb;
      f_r[0] <= '0;
    end
  end

  for (genvar s = 1; s <= 32; s++) begin : g_sq
    logic [63:0] sq;
    logic [32:0] sh;
    assign sq = 64'(m_r[s-1]) * 64'(m_r[s-1]);
    assign sh = sq[63:31];
    always_ff @(posedge clk) begin
      if (ce) begin
        m_r[s] <= sh[32] ? sh[32:1] : sh[31:0];
        f_r[s] <= f_r[s-1] | (sh[32] ? (32'd1 << (32 - s)) : 32'd0);
        n_r[s] <= n_r[s-1];
      end
    end
  end

  assign lg = {n_r[32], f_r[32]};
endmodule
`default_nettype wire

FILE: design/nu_mut_exp2.sv
// Pipelined 2^-t: frac*ln2, then a 16-term series, three stages per term after the first.
`default_nettype none
module nu_mut_exp2
  import nu_mut_pkg::*;
(
  input  logic           clk,
  input  logic           ce,
  input  logic [T_W-1:0] t,
  output logic [Q_W-1:0] e
);
  logic [12:0] ti1_r;
  logic [31:0] y1_r;
  logic [63:0] ym;

  logic [31:0] pa_r [0:NTERM-1];
  logic [31:0] ya_r [0:NTERM-1];
  logic [33:0] sa_r [0:NTERM-1];
  logic [12:0] tia_r[0:NTERM-1];
  logic [31:0] pb_r [0:NTERM-1];
  logic [31:0] qb_r [0:NTERM-1];
  logic [31:0] yb_r [0:NTERM-1];
  logic [33:0] sb_r [0:NTERM-1];
  logic [12:0] tib_r[0:NTERM-1];
  logic [31:0] tc_r [0:NTERM-1];
  logic [31:0] yc_r [0:NTERM-1];
  logic [33:0] sc_r [0:NTERM-1];
  logic [12:0] tic_r[0:NTERM-1];
  logic [Q_W-1:0] e_r;

  assign ym = 64'(t[31:0]) * 64'(LN2_Q32);

  always_ff @(posedge clk) begin
    if (ce) begin
      ti1_r <= t[T_W-1:32];
      y1_r  <= ym[63:32];
    end
  end

  for (genvar j = 0; j < NTERM; j++) begin : g_term
    localparam logic [31:0] DIV   = 32'(j + 2);
    localparam logic [35:0] RECIP = 36'((64'd1 << 36) / (j + 2));
    logic [31:0] term_in, y_in;
    logic [33:0] sum_in;
    logic [12:0] ti_in;
    logic [63:0] pm;
    logic [67:0] qm;
    logic [31:0] rem, q_fix;

    if (j == 0) begin : g_first
      // first term is y itself
      assign term_in = y1_r;
      assign y_in    = y1_r;
      assign sum_in  = 34'(ONE_Q32) - 34'(y1_r);
      assign ti_in   = ti1_r;
    end else begin : g_next
      assign term_in = tc_r[j-1];
      assign y_in    = yc_r[j-1];
      assign sum_in  = sc_r[j-1];
      assign ti_in   = tic_r[j-1];
    end

    assign pm    = 64'(term_in) * 64'(y_in);
    assign qm    = 68'(pa_r[j]) * 68'(RECIP);
    // reciprocal quotient is at most one short
    assign rem   = pb_r[j] - 32'(qb_r[j] * DIV);
    assign q_fix = qb_r[j] + ((rem >= DIV) ? 32'd1 : 32'd0);

    always_ff @(posedge clk) begin
      if (ce) begin
        pa_r[j]  <= pm[63:32];
        ya_r[j]  <= y_in;
        sa_r[j]  <= sum_in;
        tia_r[j] <= ti_in;

        pb_r[j]  <= pa_r[j];
        qb_r[j]  <= qm[67:36];
        yb_r[j]  <= ya_r[j];
        sb_r[j]  <= sa_r[j];
        tib_r[j] <= tia_r[j];

        tc_r[j]  <= q_fix;
        yc_r[j]  <= yb_r[j];
        sc_r[j]  <= (j % 2 == 0) ? sb_r[j] + 34'(q_fix) : sb_r[j] - 34'(q_fix);
        tic_r[j] <= tib_r[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      if (tic_r[NTERM-1] >= 13'd40) e_r <= '0;
      else e_r <= Q_W'(sc_r[NTERM-1] >> tic_r[NTERM-1][5:0]);
    end
  end

  assign e = e_r;
endmodule
`default_nettype wire

FILE: design/nu_mut_checker.sv
// Port-level checks of the mutation block, bound to the top level.
`default_nettype none
module nu_mut_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic signed [31:0]   out_mutated_value
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_mutated_value))
    else $error("output transaction dropped or changed under stall");

  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_mutated_value <= 32'sd1073741824) &&
                  (out_mutated_value >= -32'sd1073741824))
    else $error("mutated value outside [-1,1]");

  a_no_block: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input held off with empty output register");

  a_rst_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid straight after reset");
endmodule

bind non_uniform_mutation nu_mut_checker u_nu_mut_checker (
  .clk(clk), .rst_n(rst_n),
  .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready),
  .out_mutated_value(out_mutated_value)
);
`default_nettype wire

FILE: bench/tb_non_uniform_mutation.sv
// Self-checking testbench for the non-uniform mutation pipeline.
`default_nettype none
module tb_non_uniform_mutation;
  import nu_mut_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LAT_WAIT = PIPE_DEPTH + 20;
  localparam int unsigned WDOG_MAX = 20000;
  localparam int unsigned N_RAND   = 700;

  localparam logic signed [31:0] POS_ONE = 32'sh4000_0000;
  localparam logic signed [31:0] NEG_ONE = -32'sh4000_0000;

  typedef struct packed {
    logic signed [31:0] x;
    logic               up;
    logic [31:0]        r;
    logic [31:0]        it;
    logic               chk;   // typed-in expectation present
    logic signed [31:0] want;
  } stim_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] in_component_value = '0;
  logic in_move_up = 1'b0;
  logic [31:0] in_uniform_fraction = '0;
  logic [31:0] in_iteration = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_mutated_value;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_wdata = '0;

  logic [31:0] budget;
  logic [23:0] shape_b;
  logic signed [31:0] mutated_q[$];
  int unsigned n_err = 0;
  int unsigned idle_cycles = 0;
  bit drain_done = 1'b0;
  bit timed_out = 1'b0;
  bit calm = 1'b0;      // no idling on either side
  bit hold_off = 1'b0;  // receiver held off for pressure

  always #10 clk = ~clk;

  non_uniform_mutation dut (.*);

  function automatic logic [63:0] log2_fix(logic [63:0] v);
    int n;
    logic [63:0] m, frac;
    n = 0;
    frac = '0;
    if (v == 0) return '0;
    for (int i = 63; i >= 0; i--) if (v[i]) begin n = i; break; end
    m = (n <= 31) ? v << (31 - n) : v >> (n - 31);
    for (int i = 31; i >= 0; i--) begin
      m = (m * m) >> 31;
      if (m >= 64'h1_0000_0000) begin
        frac[i] = 1'b1;
        m = m >> 1;
      end
    end
    return (64'(n) << 32) | frac;
  endfunction

  function automatic logic [63:0] pow2_neg(logic [63:0] t);
    logic [63:0] ti, y, acc, term;
    ti = t >> 32;
    y = ((t & 64'hFFFF_FFFF) * 64'(LN2_Q32)) >> 32;
    acc = 64'h1_0000_0000;
    term = acc;
    if (ti >= 40) return '0;
    for (int n = 1; n <= 16; n++) begin
      term = ((term * y) >> 32) / n;
      if (n % 2) acc = acc - term;
      else acc = acc + term;
    end
    return acc >> ti;
  endfunction

  function automatic logic [63:0] scale_q32(logic [63:0] a, logic [63:0] b);
    return (a >> 32) * b + (((a & 64'hFFFF_FFFF) * b) >> 32);
  endfunction

  function automatic logic signed [31:0] mutate(logic signed [31:0] xi, logic up,
                                                logic [31:0] r, logic [31:0] it);
    logic [63:0] e, p, k, lmax, lrem, lmag, mag, dmag;
    longint x, span, v;
    x = xi;
    if (it >= budget) e = 0;
    else begin
      lmax = log2_fix(64'(budget));
      lrem = log2_fix(64'(budget - it));
      lmag = (lmax >= lrem) ? lmax - lrem : 0;
      e = pow2_neg((64'(shape_b) * lmag) >> 16);
    end
    if (e == 0) p = 64'h1_0000_0000;
    else if (r == 0) p = 0;
    else p = pow2_neg(scale_q32((64'd32 << 32) - log2_fix(64'(r)), e));
    k = 64'h1_0000_0000 - p;
    span = up ? (longint'(POS_ONE) - x) : (longint'(POS_ONE) + x);
    mag = (span < 0) ? 64'(-span) : 64'(span);
    dmag = scale_q32(mag, k);
    if ((span < 0) ^ !up) v = x - longint'(dmag);
    else v = x + longint'(dmag);
    while (v > longint'(POS_ONE)) v -= 64'sh8000_0000;
    while (v < longint'(NEG_ONE)) v += 64'sh8000_0000;
    return v[31:0];
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_MAX_ITER) budget = val;
    else shape_b = val[23:0];
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (mutated_q.size() != 0) @(posedge clk);
    repeat (LAT_WAIT) @(posedge clk);
  endtask

  task automatic send(stim_t s);
    logic signed [31:0] w;
    while (!calm && $urandom_range(99) < 30) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    w = mutate(s.x, s.up, s.r, s.it);
    if (s.chk && w !== s.want) begin
      n_err++;
      $display("directed row prediction %h differs from table %h", w, s.want);
    end
    in_valid <= 1'b1;
    in_component_value <= s.x;
    in_move_up <= s.up;
    in_uniform_fraction <= s.r;
    in_iteration <= s.it;
    do @(posedge clk); while (!in_ready);
    mutated_q.push_back(w);
  endtask

  function automatic stim_t rand_item();
    stim_t s;
    int unsigned sel;
    s = '0;
    sel = $urandom_range(9);
    s.x = (sel == 0) ? $urandom() : $signed($urandom_range(32'h8000_0000)) - POS_ONE;
    s.up = $urandom_range(1);
    s.r = ($urandom_range(19) == 0) ? 32'd0 : $urandom();
    if (budget <= 32'd1000 || $urandom_range(1)) s.it = $urandom_range(budget);
    else s.it = $urandom();
    if ($urandom_range(29) == 0) s.it = 32'hFFFF_FFFF;
    return s;
  endfunction

  // result checker
  always @(posedge clk) begin
    logic signed [31:0] w;
    if (rst_n && out_valid && out_ready) begin
      idle_cycles <= 0;
      if (mutated_q.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("unexpected transaction: got %h", out_mutated_value);
      end else begin
        w = mutated_q.pop_front();
        if (out_mutated_value !== w) begin
          n_err++;
          if (n_err <= 10)
            $display("mutated_value mismatch: expected %h, actual %h", w, out_mutated_value);
        end
      end
    end else if (rst_n && in_valid && in_ready) idle_cycles <= 0;
    else if (rst_n && !drain_done) idle_cycles <= idle_cycles + 1;
  end

  // receiver
  always @(posedge clk) begin
    if (hold_off) out_ready <= 1'b0;
    else if (calm) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(99) >= 30);
  end

  // watchdog
  always @(posedge clk) begin
    if (idle_cycles >= WDOG_MAX && !timed_out) begin
      timed_out = 1'b1;
      $display("non_uniform_mutation test failed");
      $finish;
    end
  end

  stim_t dir_tab[$];

  initial begin
    stim_t s;
    budget = MAX_ITER_RST;
    shape_b = SHAPE_RST;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    // after reset budget is 1: iteration 1 and above leaves x unmoved but for the fold into [-1,1]
    dir_tab = '{
      '{POS_ONE, 1'b1, 32'hFFFF_FFFF, 32'd1, 1'b1, POS_ONE},
      '{NEG_ONE, 1'b0, 32'h0, 32'd5, 1'b1, NEG_ONE},
      '{32'sh0, 1'b1, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 32'sh0},
      '{32'sh7FFF_FFFF, 1'b0, 32'h1, 32'd1, 1'b1, -32'sd1},
      '{32'sh8000_0000, 1'b1, 32'h1234, 32'd2, 1'b1, 32'sh0},
      '{32'sh4000_0001, 1'b1, 32'h0, 32'd1, 1'b1, -32'sh3FFF_FFFF},
      '{32'sh0, 1'b1, 32'h0, 32'd0, 1'b0, 32'sh0},
      '{32'sh0, 1'b0, 32'h0, 32'd0, 1'b0, 32'sh0},
      '{32'sh2000_0000, 1'b1, 32'h8000_0000, 32'd0, 1'b0, 32'sh0},
      '{-32'sh2000_0000, 1'b0, 32'hFFFF_FFFF, 32'd0, 1'b0, 32'sh0},
      '{32'sh7FFF_FFFF, 1'b1, 32'h4000_0000, 32'd0, 1'b0, 32'sh0},
      '{32'sh8000_0000, 1'b0, 32'h4000_0000, 32'd0, 1'b0, 32'sh0},
      '{32'sh7FFF_FFFF, 1'b0, 32'h0, 32'd0, 1'b0, 32'sh0},
      '{32'sh8000_0000, 1'b1, 32'h0, 32'd0, 1'b0, 32'sh0}
    };
    foreach (dir_tab[i]) send(dir_tab[i]);
    wait_idle();
    // zero shape exponent and huge budget: e is exactly 1 below the budget
    write_reg(CFG_MAX_ITER, 32'hFFFF_FFFF);
    write_reg(CFG_SHAPE, 32'd0);
    send('{32'sh1000_0000, 1'b1, 32'h8000_0000, 32'd0, 1'b0, 32'sh0});
    send('{32'sh1000_0000, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b0, 32'sh0});
    send('{32'sh1000_0000, 1'b0, 32'h0, 32'hFFFF_FFFF, 1'b1, 32'sh1000_0000});
    wait_idle();
    // max shape exponent: exponent underflow near the budget
    write_reg(CFG_MAX_ITER, 32'd100);
    write_reg(CFG_SHAPE, 32'h00FF_FFFF);
    send('{32'sh0, 1'b1, 32'h1, 32'd99, 1'b0, 32'sh0});
    send('{32'sh0, 1'b0, 32'h0, 32'd50, 1'b0, 32'sh0});
    wait_idle();
    // zero budget: every iteration has reached it
    write_reg(CFG_MAX_ITER, 32'd0);
    send('{32'sh1234_5678, 1'b1, 32'h0, 32'd0, 1'b1, 32'sh1234_5678});
    wait_idle();

    // random phases over several settings; pressure on the first
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin write_reg(CFG_MAX_ITER, 32'd1000); write_reg(CFG_SHAPE, SHAPE_RST); end
        1: begin write_reg(CFG_MAX_ITER, $urandom()); write_reg(CFG_SHAPE, $urandom()); end
        2: begin write_reg(CFG_MAX_ITER, 32'd1); write_reg(CFG_SHAPE, 32'h0001_0000); end
        3: begin write_reg(CFG_MAX_ITER, 32'hFFFF_FFFF); write_reg(CFG_SHAPE, 32'h00FF_FFFF); end
        default: begin
          write_reg(CFG_MAX_ITER, $urandom_range(5000, 2));
          write_reg(CFG_SHAPE, $urandom_range(32'h0010_0000));
        end
      endcase
      if (ph == 0) fork
        begin
          hold_off = 1'b1;
          repeat (PIPE_DEPTH * 3) @(posedge clk);
          hold_off = 1'b0;
        end
      join_none
      calm = (ph == 2);
      for (int n = 0; n < N_RAND / 5; n++) begin
        s = rand_item();
        send(s);
      end
      wait_idle();
    end
    drain_done = 1'b1;
    if (n_err == 0) $display("non_uniform_mutation test passed");
    else $display("non_uniform_mutation test failed");
    $finish;
  end

endmodule
`default_nettype wire
